>>> hw/rtl/tffs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tffs_pkg
// shared widths, register indexes, types and states of the feature selector
// ----------------------------------------------------------------------------
package tffs_pkg;

    localparam int MAX_FEATURES_DEF = 64;

    localparam int TAG_W      = 16;
    localparam int STRENGTH_W = 32;
    localparam int FRACTION_W = 17;
    localparam int MINIMUM_W  = 12;
    localparam int FRAC_SHIFT = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_TOP_FRACTION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_KEPT = 1'b1;

    localparam logic [FRACTION_W-1:0] FRACTION_RESET = 17'd13107;
    localparam logic [MINIMUM_W-1:0]  MINIMUM_RESET  = 12'd100;

    typedef struct packed {
        logic [STRENGTH_W-1:0] strength;
        logic [TAG_W-1:0]      tag;
    } t_feature;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_up;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MULT,
        S_CLAMP,
        S_EMIT
    } t_state;

endpackage : tffs_pkg
`default_nettype wire

>>> hw/rtl/tffs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tffs_if
// feature, kept-feature and configuration write channels
// ----------------------------------------------------------------------------
interface tffs_in_if;
    import tffs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [TAG_W-1:0]      feature_tag;
    logic [STRENGTH_W-1:0] strength;
    logic                  final_item;

    modport source (output valid, feature_tag, strength, final_item, input ready);
    modport sink   (input valid, feature_tag, strength, final_item, output ready);
endinterface : tffs_in_if

interface tffs_out_if;
    import tffs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [TAG_W-1:0]      kept_tag;
    logic [STRENGTH_W-1:0] kept_strength;
    logic                  run_end;

    modport source (output valid, kept_tag, kept_strength, run_end, input ready);
    modport sink   (input valid, kept_tag, kept_strength, run_end, output ready);
endinterface : tffs_out_if

interface tffs_cfg_if;
    import tffs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : tffs_cfg_if
`default_nettype wire

>>> hw/rtl/tffs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tffs_cell
// one slot of the sorted chain: insert, move down, or move up
// ----------------------------------------------------------------------------
module tffs_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CW         = 7
) (
    input  wire                   i_clk,
    input  tffs_pkg::t_cell_ctrl  i_ctrl,
    input  wire [CW-1:0]          i_count,
    input  tffs_pkg::t_feature    i_new,
    input  wire                   i_prev_take,
    input  tffs_pkg::t_feature    i_prev,
    input  tffs_pkg::t_feature    i_next,
    output logic                  o_take,
    output tffs_pkg::t_feature    o_held
);
    import tffs_pkg::*;

    t_feature r_held;
    t_feature n_held;
    logic     w_occupied;

    assign w_occupied = CW'(CELL_INDEX) < i_count;
    // strict compare keeps earlier arrivals ahead on equal strength
    assign o_take = !w_occupied || (r_held.strength < i_new.strength);
    assign o_held = r_held;

    always_comb begin
        n_held = r_held;
        if (i_ctrl.insert) begin
            if (o_take && !i_prev_take) begin
                n_held = i_new;
            end else if (o_take) begin
                n_held = i_prev;
            end
        end else if (i_ctrl.shift_up) begin
            n_held = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule : tffs_cell
`default_nettype wire

>>> hw/rtl/tffs_cutoff.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tffs_cutoff
// kept count: max(minimum, fraction * count >> 16) clamped to count
// ----------------------------------------------------------------------------
module tffs_cutoff #(
    parameter int CW = 7
) (
    input  wire                              i_clk,
    input  wire [tffs_pkg::FRACTION_W-1:0]   i_fraction,
    input  wire [tffs_pkg::MINIMUM_W-1:0]    i_minimum,
    input  wire [CW-1:0]                     i_count,
    output logic [CW-1:0]                    o_cutoff
);
    import tffs_pkg::*;

    localparam int PROD_W = FRACTION_W + CW;
    localparam int FRAC_W = PROD_W - FRAC_SHIFT;
    localparam int CMP_W  = (FRAC_W > MINIMUM_W) ? FRAC_W : MINIMUM_W;

    logic [PROD_W-1:0] r_product;
    logic [PROD_W-1:0] w_frac_ext;
    logic [PROD_W-1:0] w_cnt_ext;
    logic [CMP_W-1:0]  w_frac_term;
    logic [CMP_W-1:0]  w_min_term;
    logic [CMP_W-1:0]  w_cnt_term;
    logic [CMP_W-1:0]  w_larger;

    assign w_frac_ext = PROD_W'(i_fraction);
    assign w_cnt_ext  = PROD_W'(i_count);

    always_ff @(posedge i_clk) begin
        r_product <= w_frac_ext * w_cnt_ext;
    end

    assign w_frac_term = CMP_W'(r_product[PROD_W-1:FRAC_SHIFT]);
    assign w_min_term  = CMP_W'(i_minimum);
    assign w_cnt_term  = CMP_W'(i_count);
    assign w_larger    = (w_min_term > w_frac_term) ? w_min_term : w_frac_term;

    always_comb begin
        if (w_larger > w_cnt_term) begin
            o_cutoff = i_count;
        end else begin
            o_cutoff = w_larger[CW-1:0];
        end
    end

endmodule : tffs_cutoff
`default_nettype wire

>>> hw/rtl/top_fraction_feature_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_fraction_feature_selector
// keeps the strongest fraction of a feature set, strongest first
// ----------------------------------------------------------------------------
// load: one feature transfer per cycle; the insertion chain keeps the set
//   sorted as it arrives, so no sort pass follows the final feature
// after the final feature: S_MULT registers the product, S_CLAMP takes the kept
//   count, then, if any are kept, one kept feature per cycle while o_kept.ready is high
// reset (synchronous, active low) empties the set and restores the registers
// ----------------------------------------------------------------------------
module top_fraction_feature_selector #(
    parameter int MAX_FEATURES = tffs_pkg::MAX_FEATURES_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tffs_in_if.sink         i_feature,
    tffs_out_if.source      o_kept,
    tffs_cfg_if.sink        i_cfg
);
    import tffs_pkg::*;

    // count holds 0..MAX_FEATURES
    localparam int CW = $clog2(MAX_FEATURES + 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [CW-1:0]          r_remaining;
    logic [CW-1:0]          n_remaining;
    logic [FRACTION_W-1:0]  r_fraction;
    logic [MINIMUM_W-1:0]   r_minimum;

    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic                   w_cfg_xfer;
    logic                   w_room;
    logic [CW-1:0]          w_cutoff;
    t_cell_ctrl             w_ctrl;
    t_feature               w_new;
    logic                   w_take [MAX_FEATURES];
    t_feature               w_held [MAX_FEATURES];

    // ---------------- handshakes ----------------
    assign w_in_xfer  = i_feature.valid && i_feature.ready;
    assign w_out_xfer = o_kept.valid && o_kept.ready;
    assign w_cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    // full store drops the feature, but a final one still closes the set
    assign w_room = r_count < CW'(MAX_FEATURES);

    assign w_new.strength = i_feature.strength;
    assign w_new.tag      = i_feature.feature_tag;

    assign w_ctrl.insert   = w_in_xfer && w_room;
    assign w_ctrl.shift_up = w_out_xfer;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fraction <= FRACTION_RESET;
            r_minimum  <= MINIMUM_RESET;
        end else if (w_cfg_xfer) begin
            unique case (i_cfg.index)
                REG_TOP_FRACTION: r_fraction <= i_cfg.data[FRACTION_W-1:0];
                REG_MINIMUM_KEPT: r_minimum  <= i_cfg.data[MINIMUM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- insertion chain, cell 0 holds the strongest ----------------
    genvar g;
    generate
        for (g = 0; g < MAX_FEATURES; g++) begin : g_cell
            logic     w_prev_take;
            t_feature w_prev;
            t_feature w_next;

            if (g == 0) begin : g_head
                assign w_prev_take = 1'b0;
                assign w_prev      = w_new;
            end else begin : g_body
                assign w_prev_take = w_take[g-1];
                assign w_prev      = w_held[g-1];
            end

            if (g == MAX_FEATURES - 1) begin : g_tail
                assign w_next = w_new;
            end else begin : g_inner
                assign w_next = w_held[g+1];
            end

            tffs_cell #(
                .CELL_INDEX (g),
                .CW         (CW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_count     (r_count),
                .i_new       (w_new),
                .i_prev_take (w_prev_take),
                .i_prev      (w_prev),
                .i_next      (w_next),
                .o_take      (w_take[g]),
                .o_held      (w_held[g])
            );
        end
    endgenerate

    // ---------------- cutoff ----------------
    tffs_cutoff #(
        .CW (CW)
    ) u_cutoff (
        .i_clk      (i_clk),
        .i_fraction (r_fraction),
        .i_minimum  (r_minimum),
        .i_count    (r_count),
        .o_cutoff   (w_cutoff)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_remaining = r_remaining;
        unique case (r_state)
            S_LOAD: begin
                if (w_ctrl.insert) begin
                    n_count = r_count + CW'(1);
                end
                if (w_in_xfer && i_feature.final_item) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_remaining = w_cutoff;
                if (w_cutoff == '0) begin
                    // nothing kept, the set is simply dropped
                    n_state = S_LOAD;
                    n_count = '0;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_xfer) begin
                    n_remaining = r_remaining - CW'(1);
                    if (r_remaining == CW'(1)) begin
                        n_state = S_LOAD;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_remaining <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remaining <= n_remaining;
        end
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        i_feature.ready = 1'b0;
        o_kept.valid    = 1'b0;
        unique case (r_state)
            S_LOAD:  i_feature.ready = 1'b1;
            S_EMIT:  o_kept.valid    = 1'b1;
            default: ;
        endcase
    end

    // head of the chain is the next kept feature
    assign o_kept.kept_tag      = w_held[0].tag;
    assign o_kept.kept_strength = w_held[0].strength;
    assign o_kept.run_end       = r_remaining == CW'(1);

    // ---------------- assertions ----------------
    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kept.valid |-> (r_remaining != '0) && (r_remaining <= r_count))
        else $error("emitting with no kept feature left");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FEATURES))
        else $error("feature count beyond store depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_feature.ready && o_kept.valid))
        else $error("loading and emitting at once");

    a_run_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_kept.run_end) |=> (r_count == '0) && i_feature.ready)
        else $error("set not emptied after last kept feature");

    a_cutoff_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP) |=> (r_remaining == $past(w_cutoff)))
        else $error("kept count not taken from cutoff");

endmodule : top_fraction_feature_selector
`default_nettype wire
